// ===== hw/rtl/sofd_pkg.sv =====
// Package for the frame deframer: byte codes, parser phase codes, result kinds
// and the result record type. No dependencies.
`default_nettype none

package sofd_pkg;

  localparam logic [7:0] START_BYTE  = 8'h5C;
  localparam logic [7:0] END_BYTE    = 8'hC5;
  localparam logic [7:0] TARGET_MASK = 8'hF0;
  localparam logic [7:0] MODULE_MASK = 8'h0F;

  localparam int unsigned PHASE_W = 4;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_ADDR0   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ADDR1   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_ADDR2   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_ADDR3   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_LENGTH  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd7;
  localparam logic [PHASE_W-1:0] PH_END     = 4'd8;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_BAD_END  = 2'd2;
  localparam logic [1:0] KIND_STRAY    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [3:0]  target;
    logic [3:0]  module_res;
    logic [31:0] ip_addr;
    logic [7:0]  payload_size;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sof_eof_frame_deframer_unit.sv =====
// Start/end-delimited frame deframer: one received byte per item in, payload,
// frame-status and stray-byte items out. Depends on sofd_pkg, sofd_parser, sofd_out_fifo.
// A result is offered on m_tvalid once its byte has passed the input register and the result buffer.
// Throughput: one byte per cycle while the result buffer has a free slot; the parser
// steps between the input register and the two-entry result buffer.
// Reset (rst, synchronous): parser back to idle, frame fields cleared, buffers empty.
`default_nettype none

module sof_eof_frame_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result item stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                      // [19:16] target, [23:20] module_res,
                                      // [55:24] ip_addr, [63:56] payload_size
  output logic [1:0]       m_tuser    // [1:0] kind
);
  import sofd_pkg::*;

  // Input register: hold one byte until the parser can take it.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       fifo_ready;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // The parser advances only when the result buffer has a free slot, so a
  // result formed in this cycle always has somewhere to go.
  assign fire     = in_valid && fifo_ready;
  assign s_tready = !in_valid || fifo_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sofd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result buffer: its ready is registered, which parts the output side
  // from the input side; a stalled sink never drops a result.
  sofd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_data (res),
    .ready     (fifo_ready),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign m_tdata = {out_res.payload_size, out_res.ip_addr, out_res.module_res,
                    out_res.target, out_res.byte_index, out_res.data_byte};
  assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

// ===== hw/rtl/sofd_parser.sv =====
// Frame parser core: phase register, frame field registers and the per-byte
// decode that forms at most one result. Depends on sofd_pkg.
`default_nettype none

module sofd_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output sofd_pkg::result_t     res
);
  import sofd_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [3:0]         header_target, header_target_next;
  logic [3:0]         header_module, header_module_next;
  logic [31:0]        address_accum, address_accum_next;
  logic [7:0]         length_reg, length_reg_next;
  logic [7:0]         payload_count, payload_count_next;
  logic [7:0]         count_inc;

  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    header_target_next = header_target;
    header_module_next = header_module;
    address_accum_next = address_accum;
    length_reg_next    = length_reg;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.data_byte      = rx_byte;
    res.byte_index     = '0;
    res.target         = header_target;
    res.module_res     = header_module;
    res.ip_addr        = address_accum;
    res.payload_size   = length_reg;
    unique case (phase)
      PH_HEADER: begin
        header_target_next = 4'((rx_byte & TARGET_MASK) >> 4);
        header_module_next = 4'(rx_byte & MODULE_MASK);
        phase_next         = PH_ADDR0;
      end
      PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
        address_accum_next = {address_accum[23:0], rx_byte};
        phase_next         = phase + PHASE_W'(1);
      end
      PH_LENGTH: begin
        length_reg_next    = rx_byte;
        payload_count_next = '0;
        phase_next         = (rx_byte == 8'd0) ? PH_END : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.byte_index     = payload_count;
        payload_count_next = count_inc;
        if (count_inc == length_reg) begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        res_valid  = 1'b1;
        res.kind   = (rx_byte == END_BYTE) ? KIND_ACCEPTED : KIND_BAD_END;
        phase_next = PH_IDLE;
      end
      default: begin
        // idle and unused codes: wait for the start byte
        phase_next = PH_IDLE;
        if (rx_byte == START_BYTE) begin
          header_target_next = '0;
          header_module_next = '0;
          address_accum_next = '0;
          length_reg_next    = '0;
          payload_count_next = '0;
          phase_next         = PH_HEADER;
        end else begin
          res_valid        = 1'b1;
          res.kind         = KIND_STRAY;
          res.target       = '0;
          res.module_res   = '0;
          res.ip_addr      = '0;
          res.payload_size = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_target <= '0;
      header_module <= '0;
      address_accum <= '0;
      length_reg    <= '0;
      payload_count <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      header_target <= header_target_next;
      header_module <= header_module_next;
      address_accum <= address_accum_next;
      length_reg    <= length_reg_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sofd_out_fifo.sv =====
// Two-entry result buffer with a registered ready; entry 0 drives the output.
// Depends on sofd_pkg.
`default_nettype none

module sofd_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sofd_pkg::result_t push_data,
  output logic                   ready,
  output logic                   out_valid,
  output sofd_pkg::result_t      out_data,
  input  wire logic              out_ready
);
  import sofd_pkg::*;

  result_t    entry [2];
  logic [1:0] count;
  logic       pop;
  logic       wr_idx;

  assign pop       = (count != 2'd0) && out_ready;
  assign ready     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[0];
  // write slot after a possible shift
  assign wr_idx    = 1'((count - {1'b0, pop}) & 2'd1);

  // A push into slot 0 takes the place of the shift from slot 1.
  always_ff @(posedge clk) begin
    if (push && !wr_idx) begin
      entry[0] <= push_data;
    end else if (pop) begin
      entry[0] <= entry[1];
    end
    if (push && wr_idx) begin
      entry[1] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_sof_eof_frame_deframer_unit.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sof_eof_frame_deframer_unit: drives received bytes,
// predicts payload, frame-status and stray-byte items, and checks each one.
// Depends on sofd_pkg and the deframer RTL.

module tb_sof_eof_frame_deframer_unit;

  import sofd_pkg::*;

  // Tracks the parser state, queues the items each accepted byte should
  // produce, and compares the items that come out of the block.
  class deframe_scoreboard;
    logic [PHASE_W-1:0] phase;
    logic [3:0]         hdr_target;
    logic [3:0]         hdr_module;
    logic [31:0]        addr_accum;
    logic [7:0]         frame_len;
    logic [7:0]         payload_idx;
    result_t            pending_items[$];
    int unsigned        errors;

    function new();
      phase = PH_IDLE;
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      hdr_target  = '0;
      hdr_module  = '0;
      addr_accum  = '0;
      frame_len   = '0;
      payload_idx = '0;
    endfunction

    function result_t frame_item(logic [1:0] kind, logic [7:0] b, logic [7:0] idx);
      result_t r;
      r.kind         = kind;
      r.data_byte    = b;
      r.byte_index   = idx;
      r.target       = hdr_target;
      r.module_res   = hdr_module;
      r.ip_addr      = addr_accum;
      r.payload_size = frame_len;
      return r;
    endfunction

    // Advance the parser by one accepted byte; queue the item it causes, if any.
    function void take_rx_byte(logic [7:0] b);
      result_t r;
      bit      has_item;
      r = '0;
      has_item = 1'b0;
      case (phase)
        PH_HEADER: begin
          hdr_target = 4'((b & TARGET_MASK) >> 4);
          hdr_module = 4'(b & MODULE_MASK);
          phase = PH_ADDR0;
        end
        PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
          addr_accum = {addr_accum[23:0], b};
          phase = phase + 1'b1;
        end
        PH_LENGTH: begin
          frame_len   = b;
          payload_idx = '0;
          phase = (b == 8'd0) ? PH_END : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          r = frame_item(KIND_PAYLOAD, b, payload_idx);
          has_item = 1'b1;
          payload_idx = payload_idx + 8'd1;
          if (payload_idx == frame_len) phase = PH_END;
        end
        PH_END: begin
          r = frame_item((b == END_BYTE) ? KIND_ACCEPTED : KIND_BAD_END, b, 8'd0);
          has_item = 1'b1;
          phase = PH_IDLE;
        end
        default: begin
          phase = PH_IDLE;
          if (b == START_BYTE) begin
            clear_frame();
            phase = PH_HEADER;
          end else begin
            r.kind      = KIND_STRAY;
            r.data_byte = b;
            has_item = 1'b1;
          end
        end
      endcase
      if (has_item) pending_items.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [63:0] data);
      result_t want;
      if (pending_items.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual kind %0d data %h",
                 $time, kind, data);
        errors++;
        return;
      end
      want = pending_items.pop_front();
      compare_field("kind",         32'(want.kind),         32'(kind));
      compare_field("data_byte",    32'(want.data_byte),    32'(data[7:0]));
      compare_field("byte_index",   32'(want.byte_index),   32'(data[15:8]));
      compare_field("target",       32'(want.target),       32'(data[19:16]));
      compare_field("module_res",   32'(want.module_res),   32'(data[23:20]));
      compare_field("ip_addr",      want.ip_addr,           data[55:24]);
      compare_field("payload_size", 32'(want.payload_size), 32'(data[63:56]));
    endfunction
  endclass

  localparam int unsigned PHASE_ITEMS = 282;   // bytes per idling phase
  localparam int unsigned STALL_LIMIT = 4000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_WAIT  = 8;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;            // [7:0] data_byte, [15:8] byte_index, [19:16] target,
                                   // [23:20] module_res, [55:24] ip_addr,
                                   // [63:56] payload_size
  logic [1:0]  m_tuser;            // [1:0] kind

  deframe_scoreboard sb = new();

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned quiet_cycles   = 0;

  sof_eof_frame_deframer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor both streams at the edge. An input byte is noted before the
  // output is checked, so a result offered in the same cycle as its byte would still find its entry.
  // The sink's ready is re-rolled every cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_rx_byte(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: count cycles in which neither stream moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_sof_eof_frame_deframer_unit NOT OK");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until the block takes it. Valid stays high
  // into the next call, so back-to-back bytes stream without a bubble.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // One complete frame: start, header, address high byte first, length,
  // random payload, then the given end byte.
  task automatic send_frame(input logic [7:0] hdr, input logic [31:0] addr,
                            input logic [7:0] len, input logic [7:0] eof);
    send_byte(START_BYTE);
    send_byte(hdr);
    for (int i = 3; i >= 0; i--) send_byte(addr[8*i +: 8]);
    send_byte(len);
    for (int i = 0; i < int'(len); i++) send_byte(8'($urandom_range(255)));
    send_byte(eof);
  endtask

  // Random traffic: mostly well-formed frames with short payloads, some
  // longer ones, a few near the maximum, occasional wrong end bytes and
  // stray noise between frames.
  task automatic send_random_unit();
    int unsigned pick;
    int unsigned len_pick;
    logic [7:0]  len;
    logic [7:0]  eof;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      len_pick = $urandom_range(99);
      if (len_pick < 85)      len = 8'($urandom_range(6));
      else if (len_pick < 98) len = 8'($urandom_range(40, 7));
      else                    len = 8'($urandom_range(255, 200));
      eof = ($urandom_range(99) < 85) ? END_BYTE : 8'($urandom_range(255));
      send_frame(8'($urandom_range(255)), $urandom(), len, eof);
    end
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    int unsigned phase_base;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray bytes at both extremes, a zero-length frame closed
    // correctly, a frame whose header is the start byte carrying the start
    // byte as payload and then as a bad end byte (consumed, not a new frame),
    // and a lone end byte while idle.
    directed_bytes = '{8'h00, 8'hFF,
                       START_BYTE, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, END_BYTE,
                       START_BYTE, START_BYTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02,
                       START_BYTE, 8'hFF, START_BYTE,
                       END_BYTE};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // Idling phases: none, sender only, receiver only, both.
    phase_base = bytes_sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      // The first phase opens with a maximum-length payload so the last byte index is reached.
      if (p == 0) send_frame(8'($urandom_range(255)), $urandom(), 8'hFF, END_BYTE);
      while (bytes_sent < phase_base + (p + 1) * PHASE_ITEMS) send_random_unit();
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every expected item, then wait out DRAIN_WAIT to catch
    // anything extra; the watchdog bounds the wait.
    while (sb.pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_sof_eof_frame_deframer_unit OK");
    end else begin
      $display("tb_sof_eof_frame_deframer_unit NOT OK");
    end
    $finish;
  end

endmodule
